FILE: hw/rtl/gre_pkg.sv
`timescale 1ns / 1ps

package gre_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int TYPE_W  = 3;
  localparam int VTX_W   = 6;
  localparam int VCNT_W  = 7;
  localparam int CNT_W   = 13;
  localparam int TDATA_W = 16;

  localparam logic [VCNT_W-1:0] VCOUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0]  COUNT_MAX  = 13'h1FFF;

  // request codes; 5..7 are ignored
  localparam logic [TYPE_W-1:0] REQ_INS_DIR = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INS_UND = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_REM_DIR = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_REM_UND = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REACH   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD_FROM,
    ST_RD_TO,
    ST_MOD_TO,
    ST_PICK,
    ST_EXPAND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_from;
    logic upd_from;
    logic rd_to;
    logic upd_to;
    logic q_init;
    logic q_pick;
    logic q_expand;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_ok;
    logic is_query;
    logic is_undirected;
    logic need;
    logic frontier_empty;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/graph_reachability_engine_unit.sv
// Reachability engine over an adjacency bit matrix of MAX_VERTICES rows, kept in
// one RAM and empty after reset (per-row valid flags, no clearing pass). Each request
// gives exactly one result. Every row update is a read-modify-write through the single
// RAM read port; an undirected change that alters the matrix updates both rows, and an
// ignored request goes straight to its result. A reach query searches from the start
// vertex and expands one frontier vertex per row read until the frontier is empty.
// One request is in work at a time; a finished result waits in the output register
// while the next request is taken. vertex_count takes effect for requests accepted
// after the write.
`timescale 1ns / 1ps

module graph_reachability_engine_unit #(
  parameter int MAX_VERTICES = gre_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gre_pkg::VCNT_W-1:0]  cfg_wdata,   // vertex_count
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [2:0] req_type, [8:3] from_vertex, [14:9] to_vertex, [15] zero
  input  logic [gre_pkg::TDATA_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] reachable, [1] changed, [14:2] arc_count, [15] zero
  output logic [gre_pkg::TDATA_W-1:0] out_tdata
);

  import gre_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gre_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: hw/rtl/gre_ram.sv
`timescale 1ns / 1ps

module gre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/gre_ctrl.sv
`timescale 1ns / 1ps

module gre_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  gre_pkg::sts_t sts,
  output gre_pkg::cmd_t cmd
);

  import gre_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts.req_ok) begin
          state_nxt = ST_DONE;
        end else if (sts.is_query) begin
          cmd.q_init = 1'b1;
          state_nxt  = ST_PICK;
        end else begin
          cmd.rd_from = 1'b1;
          state_nxt   = ST_MOD_FROM;
        end
      end
      ST_MOD_FROM: begin
        cmd.upd_from = 1'b1;
        if (sts.need && sts.is_undirected) begin
          state_nxt = ST_RD_TO;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_TO: begin
        cmd.rd_to = 1'b1;
        state_nxt = ST_MOD_TO;
      end
      ST_MOD_TO: begin
        cmd.upd_to = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_PICK: begin
        if (sts.frontier_empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.q_pick = 1'b1;
          state_nxt  = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cmd.q_expand = 1'b1;
        state_nxt    = ST_PICK;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/gre_dp.sv
`timescale 1ns / 1ps

module gre_dp #(
  parameter int MAX_VERTICES = gre_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gre_pkg::VCNT_W-1:0]  cfg_wdata,
  input  logic [gre_pkg::TDATA_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gre_pkg::TDATA_W-1:0] out_tdata,
  input  gre_pkg::cmd_t               cmd,
  output gre_pkg::sts_t               sts
);

  import gre_pkg::*;

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NCAP = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;
  localparam logic [VCNT_W-1:0] NCAP_V = VCNT_W'(NCAP);

  logic [VCNT_W-1:0]       vcount_r;
  logic [TYPE_W-1:0]       type_r;
  logic [VTX_W-1:0]        from_r;
  logic [VTX_W-1:0]        to_r;
  logic [CNT_W-1:0]        arc_r;
  logic [CNT_W-1:0]        arc_nxt;
  logic                    changed_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [MAX_VERTICES-1:0] visited_nxt;
  logic [MAX_VERTICES-1:0] frontier_r;
  logic [MAX_VERTICES-1:0] frontier_nxt;
  logic [MAX_VERTICES-1:0] row_valid_r;
  logic [VW-1:0]           rd_idx_r;
  logic                    out_valid_r;
  logic [TDATA_W-1:0]      out_data_r;

  logic [VCNT_W-1:0]       n_eff;
  logic [MAX_VERTICES-1:0] nmask;
  logic [VW-1:0]           from_idx;
  logic [VW-1:0]           to_idx;
  logic [MAX_VERTICES-1:0] low_bit;
  logic [VW-1:0]           pick_idx;
  logic [VW-1:0]           raddr;
  logic [MAX_VERTICES-1:0] rdata;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [MAX_VERTICES-1:0] new_marks;
  logic                    ram_we;
  logic [VW-1:0]           waddr;
  logic [MAX_VERTICES-1:0] wdata;
  logic                    is_ins;
  logic                    type_ok;
  logic                    reach_bit;

  assign from_idx = VW'(from_r);
  assign to_idx   = VW'(to_r);

  // effective vertex count, clamped to 1..NCAP (MAX_VERTICES, at most 127)
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = VCNT_W'(1);
    end else if (vcount_r > NCAP_V) begin
      n_eff = NCAP_V;
    end else begin
      n_eff = vcount_r;
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (i < int'(n_eff));
    end
  end

  assign is_ins  = (type_r == REQ_INS_DIR) || (type_r == REQ_INS_UND);
  assign type_ok = (type_r == REQ_INS_DIR) || (type_r == REQ_INS_UND) ||
                   (type_r == REQ_REM_DIR) || (type_r == REQ_REM_UND) ||
                   (type_r == REQ_REACH);

  // lowest pending frontier vertex
  always_comb begin
    low_bit  = frontier_r & (~frontier_r + MAX_VERTICES'(1));
    pick_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (low_bit[i]) begin
        pick_idx = pick_idx | VW'(i);
      end
    end
  end

  always_comb begin
    if (cmd.rd_to) begin
      raddr = to_idx;
    end else if (cmd.q_pick) begin
      raddr = pick_idx;
    end else begin
      raddr = from_idx;
    end
  end

  gre_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rows never written since reset read as empty
  assign row_eff = row_valid_r[rd_idx_r] ? rdata : '0;

  always_comb begin
    ram_we = 1'b0;
    waddr  = from_idx;
    wdata  = row_eff;
    if (cmd.upd_from) begin
      ram_we        = sts.need;
      wdata[to_idx] = is_ins;
    end else if (cmd.upd_to) begin
      ram_we          = 1'b1;
      waddr           = to_idx;
      wdata[from_idx] = is_ins;
    end
  end

  always_comb begin
    sts.req_ok         = type_ok && ({1'b0, from_r} < n_eff) && ({1'b0, to_r} < n_eff);
    sts.is_query       = (type_r == REQ_REACH);
    sts.is_undirected  = (type_r == REQ_INS_UND) || (type_r == REQ_REM_UND);
    sts.need           = is_ins ? !row_eff[to_idx] : row_eff[to_idx];
    sts.frontier_empty = (frontier_r == '0);
    sts.out_free       = !out_valid_r || out_tready;
  end

  always_comb begin
    arc_nxt = arc_r;
    if (cmd.upd_from && sts.need) begin
      if (is_ins) begin
        arc_nxt = (arc_r == COUNT_MAX) ? arc_r : arc_r + CNT_W'(1);
      end else begin
        arc_nxt = (arc_r == '0) ? arc_r : arc_r - CNT_W'(1);
      end
    end
  end

  assign new_marks = row_eff & nmask & ~visited_r;

  always_comb begin
    visited_nxt  = visited_r;
    frontier_nxt = frontier_r;
    if (cmd.q_init) begin
      visited_nxt           = '0;
      visited_nxt[from_idx] = 1'b1;
      frontier_nxt          = visited_nxt;
    end else if (cmd.q_pick) begin
      frontier_nxt[pick_idx] = 1'b0;
    end else if (cmd.q_expand) begin
      visited_nxt  = visited_r | new_marks;
      frontier_nxt = frontier_r | new_marks;
    end
  end

  assign reach_bit = sts.is_query && sts.req_ok && visited_r[to_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= VCOUNT_RST;
      arc_r       <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      arc_r <= arc_nxt;
      if (ram_we) begin
        row_valid_r[waddr] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= in_tdata[TYPE_W-1:0];
      from_r <= in_tdata[TYPE_W +: VTX_W];
      to_r   <= in_tdata[TYPE_W+VTX_W +: VTX_W];
    end
    if (cmd.capture) begin
      changed_r <= 1'b0;
    end else if (cmd.upd_from && sts.need) begin
      changed_r <= 1'b1;
    end
    rd_idx_r   <= raddr;
    visited_r  <= visited_nxt;
    frontier_r <= frontier_nxt;
    if (cmd.out_load) begin
      out_data_r <= {1'b0, arc_r, changed_r, reach_bit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/gre_chk.sv
`timescale 1ns / 1ps

module gre_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [gre_pkg::TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in work");

  // a result never appears in the cycle straight after a transfer in
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result too early after input transfer");

  // a request either changes the matrix or answers a query, never both
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("reachable and changed both set");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind graph_reachability_engine_unit gre_chk u_gre_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import gre_pkg::*;

  localparam int NV     = MAX_VERTICES_DEF;
  localparam int SETTLE = 12;

  typedef struct packed {
    logic             reachable;
    logic             changed;
    logic [CNT_W-1:0] arc_count;
  } graph_result_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [VCNT_W-1:0]   cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic [TDATA_W-1:0]  in_tdata   = '0;
  logic                out_tready = 1'b0;
  wire                 in_tready;
  wire                 out_tvalid;
  wire  [TDATA_W-1:0]  out_tdata;

  graph_reachability_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // model of the matrix, kept in step with accepted requests
  logic [NV-1:0]       arc_rows [NV];
  logic [CNT_W-1:0]    arc_total;
  logic [VCNT_W-1:0]   vertex_count_reg;
  logic [TDATA_W-1:0]  req_queue [$];
  graph_result_t       due_results [$];
  logic [11:0]         inserted_arcs [$];
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  errors = 0;

  function automatic int unsigned vertices_in_use(logic [VCNT_W-1:0] vc);
    if (vc == 0) return 1;
    if (vc > NV) return NV;
    return vc;
  endfunction

  function automatic logic [TDATA_W-1:0] pack_req(logic [TYPE_W-1:0] kind,
                                                  logic [VTX_W-1:0] v,
                                                  logic [VTX_W-1:0] w);
    return {1'b0, w, v, kind};
  endfunction

  task automatic apply_graph_request(input logic [TDATA_W-1:0] d);
    logic [TYPE_W-1:0] kind;
    int unsigned       v, w, n, u;
    graph_result_t     r;
    logic [NV-1:0]     seen, grown, follow;
    logic              spreading;
    kind = d[2:0];
    v    = d[8:3];
    w    = d[14:9];
    n    = vertices_in_use(vertex_count_reg);
    r    = '0;
    if (kind <= REQ_REACH && v < n && w < n) begin
      case (kind)
        REQ_INS_DIR, REQ_INS_UND: begin
          if (!arc_rows[v][w]) begin
            arc_rows[v][w] = 1'b1;
            if (kind == REQ_INS_UND) arc_rows[w][v] = 1'b1;
            if (arc_total != COUNT_MAX) arc_total = arc_total + 1'b1;
            r.changed = 1'b1;
          end
        end
        REQ_REM_DIR, REQ_REM_UND: begin
          if (arc_rows[v][w]) begin
            arc_rows[v][w] = 1'b0;
            if (kind == REQ_REM_UND) arc_rows[w][v] = 1'b0;
            if (arc_total != 0) arc_total = arc_total - 1'b1;
            r.changed = 1'b1;
          end
        end
        default: begin
          // closure over rows in use; arcs into unused vertices are masked off
          follow = '1;
          if (n < NV) follow = follow >> (NV - n);
          seen    = '0;
          seen[v] = 1'b1;
          spreading = 1'b1;
          while (spreading) begin
            grown = seen;
            for (u = 0; u < n; u++)
              if (seen[u]) grown = grown | (arc_rows[u] & follow);
            spreading = (grown != seen);
            seen = grown;
          end
          r.reachable = seen[w];
        end
      endcase
    end
    r.arc_count = arc_total;
    due_results.push_back(r);
  endtask

  task automatic check_graph_result(input logic [TDATA_W-1:0] d);
    graph_result_t got, want;
    got.reachable = d[0];
    got.changed   = d[1];
    got.arc_count = d[14:2];
    if (due_results.size() == 0) begin
      $error("result with nothing outstanding: tdata=%h", d);
      errors++;
    end else begin
      want = due_results.pop_front();
      if (got.reachable !== want.reachable) begin
        $error("reachable: expected %0d, got %0d", want.reachable, got.reachable);
        errors++;
      end
      if (got.changed !== want.changed) begin
        $error("changed: expected %0d, got %0d", want.changed, got.changed);
        errors++;
      end
      if (got.arc_count !== want.arc_count) begin
        $error("arc_count: expected %0d, got %0d", want.arc_count, got.arc_count);
        errors++;
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_graph_request(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= req_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_graph_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic drain();
    while (req_queue.size() != 0 || in_tvalid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [VCNT_W-1:0] vc);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= vc;
    vertex_count_reg = vc;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_req(input logic [TYPE_W-1:0] kind, input int v, input int w);
    req_queue.push_back(pack_req(kind, v[VTX_W-1:0], w[VTX_W-1:0]));
  endtask

  task automatic queue_random_reqs(input int n, input int count);
    int          i, pick, v, w, idx;
    logic [TYPE_W-1:0] kind;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      v = $urandom_range(n - 1);
      w = $urandom_range(n - 1);
      if (pick < 4) begin
        kind = TYPE_W'($urandom_range(7, 5));
        v = $urandom_range(NV - 1);
        w = $urandom_range(NV - 1);
      end else if (pick < 9) begin
        kind = TYPE_W'($urandom_range(4));
        v = $urandom_range(NV - 1);
        w = $urandom_range(NV - 1);
      end else if (pick < 39) begin
        kind = REQ_INS_DIR;
      end else if (pick < 54) begin
        kind = REQ_INS_UND;
      end else if (pick < 72) begin
        kind = (pick < 64) ? REQ_REM_DIR : REQ_REM_UND;
        // mostly hit an arc that was put in earlier
        if (inserted_arcs.size() != 0 && $urandom_range(9) < 6) begin
          idx = $urandom_range(inserted_arcs.size() - 1);
          if (inserted_arcs[idx][5:0] < n && inserted_arcs[idx][11:6] < n) begin
            v = inserted_arcs[idx][5:0];
            w = inserted_arcs[idx][11:6];
            if ($urandom_range(3) == 0) begin
              v = inserted_arcs[idx][11:6];
              w = inserted_arcs[idx][5:0];
            end
          end
        end
      end else begin
        kind = REQ_REACH;
      end
      if (kind == REQ_INS_DIR || kind == REQ_INS_UND) begin
        inserted_arcs.push_back({w[5:0], v[5:0]});
        if (inserted_arcs.size() > 256) void'(inserted_arcs.pop_front());
      end
      push_req(kind, v, w);
    end
  endtask

  int send_modes [3] = '{27, 79, 0};
  int recv_modes [3] = '{79, 27, 0};
  logic [VCNT_W-1:0] vc_plan [15] = '{7'd64, 7'd8, 7'd1, 7'd127, 7'd0,
                                      7'd2, 7'd16, 7'd64, 7'd33, 7'd5,
                                      7'd64, 7'd3, 7'd127, 7'd12, 7'd64};

  initial begin
    int mode, sub;
    for (int r = 0; r < NV; r++) arc_rows[r] = '0;
    arc_total        = '0;
    vertex_count_reg = VCOUNT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = send_modes[0];
    recv_idle_pct = recv_modes[0];

    // directed: duplicates, mirror halves, count floor, self loop, odd codes
    push_req(REQ_INS_DIR, 0, 63);
    push_req(REQ_INS_DIR, 0, 63);
    push_req(REQ_INS_UND, 63, 5);
    push_req(REQ_REM_DIR, 5, 63);
    push_req(REQ_REM_UND, 63, 5);
    push_req(REQ_REM_DIR, 63, 5);
    push_req(REQ_INS_UND, 1, 2);
    push_req(REQ_REM_DIR, 1, 2);
    push_req(REQ_REM_DIR, 2, 1);   // count already zero
    push_req(REQ_INS_DIR, 7, 7);
    push_req(REQ_REACH, 7, 7);
    push_req(REQ_REACH, 10, 10);
    push_req(REQ_INS_DIR, 63, 3);
    push_req(REQ_REACH, 0, 3);
    push_req(REQ_REACH, 3, 0);
    push_req(3'd5, 0, 63);
    push_req(3'd6, 63, 0);
    push_req(3'd7, 63, 63);
    push_req(REQ_REM_UND, 0, 63);
    push_req(REQ_INS_DIR, 2, 40);
    push_req(REQ_INS_DIR, 40, 4);
    push_req(REQ_REACH, 2, 4);

    // shrunk count: the path through vertex 40 must no longer be followed
    write_vertex_count(7'd8);
    push_req(REQ_REACH, 2, 4);
    push_req(REQ_INS_DIR, 2, 40);
    push_req(REQ_REACH, 2, 63);
    write_vertex_count(7'd0);
    push_req(REQ_REACH, 0, 0);
    push_req(REQ_INS_DIR, 0, 0);
    push_req(REQ_INS_DIR, 0, 1);
    write_vertex_count(7'd127);
    push_req(REQ_REACH, 63, 3);

    for (mode = 0; mode < 3; mode++) begin
      drain();
      send_idle_pct = send_modes[mode];
      recv_idle_pct = recv_modes[mode];
      for (sub = 0; sub < 5; sub++) begin
        write_vertex_count(vc_plan[mode * 5 + sub]);
        queue_random_reqs(vertices_in_use(vc_plan[mode * 5 + sub]), 100);
      end
    end

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
